// ===== rtl/smsg_pkg.sv =====
// ============================================================================
// smsg_pkg
// Shared types and constants for the stepper move sequencer with stall guard.
// ============================================================================
`default_nettype none
package smsg_pkg;

    localparam int HP_W   = 19;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 24;

    localparam logic [3:0] OP_TICK   = 4'd0;
    localparam logic [3:0] OP_SAMPLE = 4'd1;
    localparam logic [3:0] OP_MOVE   = 4'd2;
    localparam logic [3:0] OP_PRIME  = 4'd3;
    localparam logic [3:0] OP_REWIND = 4'd4;
    localparam logic [3:0] OP_BOLUS  = 4'd5;
    localparam logic [3:0] OP_STOP   = 4'd6;
    localparam logic [3:0] OP_CANCEL = 4'd7;
    localparam logic [3:0] OP_HOME   = 4'd8;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_MOVE_OK     = 3'd1;
    localparam logic [2:0] EV_MOVE_LOSS   = 3'd2;
    localparam logic [2:0] EV_BOLUS_DONE  = 3'd3;
    localparam logic [2:0] EV_BOLUS_ABORT = 3'd4;
    localparam logic [2:0] EV_REJECT      = 3'd5;

    localparam logic [CIDX_W-1:0] CFG_DEFAULT_SPEED = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BOLUS_SPEED   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SEG_STEPS     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SEG_PAUSE     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_NOLOAD        = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_OVERLOAD      = 3'd5;

    localparam logic [31:0] NOLOAD_AFTER_STEPS = 32'd50;

    typedef struct packed {
        logic [3:0]         opcode;
        logic               direction;
        logic [31:0]        step_amount;
        logic [15:0]        step_rate;
        logic signed [15:0] current_ma;
        logic               inhibit;
    } t_in_item;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic        enable_n;
        logic        busy_res;
        logic        bolus_running;
        logic        loss_flag;
        logic [31:0] position;
        logic [14:0] peak_ma;
        logic [31:0] delivered;
        logic [2:0]  event_res;
    } t_out_item;

    typedef struct packed {
        logic exec;
        logic sel_latched;
        logic latch;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/smsg_div.sv =====
// ============================================================================
// smsg_div
// Restoring divider: constant dividend over a 16-bit divisor, one bit a cycle.
// ============================================================================
`default_nettype none
module smsg_div #(
    parameter logic [smsg_pkg::HP_W-1:0] DIVIDEND = 19'd500000
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [15:0]               i_divisor,
    output logic                           o_done,
    output logic [smsg_pkg::HP_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(smsg_pkg::HP_W + 1);

    logic [CNT_W-1:0]          r_cnt;
    logic [15:0]               r_rem;
    logic [15:0]               r_dvs;
    logic [smsg_pkg::HP_W-1:0] r_quot;
    logic                      r_done;
    logic [16:0]               w_sh;
    logic [16:0]               w_diff;
    logic                      w_ge;

    assign w_sh   = {r_rem, r_quot[smsg_pkg::HP_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(smsg_pkg::HP_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= DIVIDEND;
            r_dvs  <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[15:0] : w_sh[15:0];
            r_quot <= {r_quot[smsg_pkg::HP_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== rtl/smsg_ctrl.sv =====
// ============================================================================
// smsg_ctrl
// Handshake and sequencing controller: direct execution or divide-then-run.
// ============================================================================
`default_nettype none
module smsg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire smsg_pkg::t_status i_status,
    output smsg_pkg::t_cmd         o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_EXEC} t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.exec        = (w_accept && !i_status.need_div) || (r_state == S_EXEC);
        o_cmd.sel_latched = (r_state == S_EXEC);
        o_cmd.latch       = w_accept && i_status.need_div;
        o_cmd.div_start   = w_accept && i_status.need_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.latch) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== rtl/smsg_dp.sv =====
// ============================================================================
// smsg_dp
// Datapath: configuration, motion state, stall guard, bolus and result register.
// ============================================================================
`default_nettype none
module smsg_dp #(
    parameter logic [smsg_pkg::HP_W-1:0] HALF_PERIOD_DIVIDEND = 19'd500000,
    parameter logic [smsg_pkg::HP_W-1:0] MIN_HALF_PERIOD      = 19'd20,
    parameter logic [15:0]               PRIME_DEFAULT_STEPS  = 16'd2000
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire smsg_pkg::t_in_item          i_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [smsg_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire logic [smsg_pkg::CDAT_W-1:0] i_cfg_data,
    input  wire smsg_pkg::t_cmd              i_cmd,
    output smsg_pkg::t_status                o_status,
    output smsg_pkg::t_out_item              o_out
);
    logic [15:0] r_def_spd, r_bol_spd, r_seg_steps;
    logic [23:0] r_seg_pause;
    logic [14:0] r_noload, r_overload;

    logic                      r_phase, n_phase;
    logic [31:0]               r_sdone, n_sdone;
    logic [31:0]               r_star, n_star;
    logic                      r_moving, n_moving;
    logic [smsg_pkg::HP_W-1:0] r_hp, n_hp;
    logic [smsg_pkg::HP_W-1:0] r_tick, n_tick;
    logic                      r_dir, n_dir;
    logic [31:0]               r_pos, n_pos;
    logic                      r_loss, n_loss;
    logic [14:0]               r_peak, n_peak;
    logic                      r_inb, n_inb;
    logic                      r_abort, n_abort;
    logic [31:0]               r_btot, n_btot;
    logic [31:0]               r_bdone, n_bdone;
    logic                      r_pausing, n_pausing;
    logic [23:0]               r_pcnt, n_pcnt;
    logic                      r_en, n_en;

    smsg_pkg::t_in_item  r_item;
    smsg_pkg::t_in_item  w_item;
    smsg_pkg::t_out_item r_out;

    logic [15:0]               w_divisor;
    logic [smsg_pkg::HP_W-1:0] w_quot;
    logic [smsg_pkg::HP_W-1:0] w_hp;
    logic                      w_div_done;

    logic [2:0]  v_ev;
    logic        v_seg;
    logic        v_move;
    logic        v_mdir;
    logic [31:0] v_msteps;
    logic [31:0] v_rem;
    logic [31:0] v_seg_sz;
    logic        v_busy;

    // Divisor follows the port item, since the divider starts at acceptance.
    always_comb begin
        if (i_item.opcode == smsg_pkg::OP_TICK || i_item.opcode == smsg_pkg::OP_BOLUS) begin
            w_divisor = r_bol_spd;
        end else begin
            w_divisor = (i_item.step_rate != 16'd0) ? i_item.step_rate : r_def_spd;
        end
        o_status.need_div = (i_item.opcode inside {smsg_pkg::OP_MOVE, smsg_pkg::OP_PRIME,
                                                   smsg_pkg::OP_REWIND, smsg_pkg::OP_BOLUS})
                            || (i_item.opcode == smsg_pkg::OP_TICK && r_pausing);
        o_status.div_done = w_div_done;
    end

    smsg_div #(.DIVIDEND(HALF_PERIOD_DIVIDEND)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (w_divisor),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign w_hp   = (w_quot < MIN_HALF_PERIOD) ? MIN_HALF_PERIOD : w_quot;
    assign w_item = i_cmd.sel_latched ? r_item : i_item;

    always_comb begin
        n_phase = r_phase;   n_sdone = r_sdone;   n_star = r_star;
        n_moving = r_moving; n_hp = r_hp;         n_tick = r_tick;
        n_dir = r_dir;       n_pos = r_pos;       n_loss = r_loss;
        n_peak = r_peak;     n_inb = r_inb;       n_abort = r_abort;
        n_btot = r_btot;     n_bdone = r_bdone;   n_pausing = r_pausing;
        n_pcnt = r_pcnt;     n_en = r_en;
        v_ev = smsg_pkg::EV_NONE;
        v_seg = 1'b0;
        v_move = 1'b0;
        v_mdir = 1'b0;
        v_msteps = '0;
        v_rem = '0;
        v_seg_sz = '0;
        v_busy = r_moving || r_inb;

        case (w_item.opcode)
            smsg_pkg::OP_TICK: begin
                if (r_pausing) begin
                    if (r_pcnt != 24'hFFFFFF) begin
                        n_pcnt = r_pcnt + 24'd1;
                    end
                    if (n_pcnt >= r_seg_pause) begin
                        v_seg = 1'b1;
                    end
                end else if (r_moving) begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= r_hp) begin
                        n_tick = '0;
                        if (!r_phase) begin
                            n_phase = 1'b1;
                        end else begin
                            n_phase = 1'b0;
                            n_sdone = r_sdone + 32'd1;
                            n_pos   = r_dir ? r_pos + 32'd1 : r_pos - 32'd1;
                            if (r_inb) begin
                                n_bdone = r_bdone + 32'd1;
                            end
                            if (n_sdone >= r_star) begin
                                n_moving = 1'b0;
                                if (!r_inb) begin
                                    n_en = 1'b1;
                                    v_ev = r_loss ? smsg_pkg::EV_MOVE_LOSS
                                                  : smsg_pkg::EV_MOVE_OK;
                                end else if (r_loss || r_abort) begin
                                    v_ev = smsg_pkg::EV_BOLUS_ABORT;
                                    n_inb = 1'b0; n_pausing = 1'b0; n_abort = 1'b0;
                                    n_en = 1'b1;
                                end else if (n_bdone >= r_btot) begin
                                    v_ev = smsg_pkg::EV_BOLUS_DONE;
                                    n_inb = 1'b0; n_pausing = 1'b0; n_abort = 1'b0;
                                    n_en = 1'b1;
                                end else begin
                                    n_pausing = 1'b1;
                                    n_pcnt = '0;
                                end
                            end
                        end
                    end
                end
            end
            smsg_pkg::OP_SAMPLE: begin
                if (r_moving) begin
                    if (w_item.current_ma > $signed({1'b0, r_peak})) begin
                        n_peak = w_item.current_ma[14:0];
                    end
                    if (w_item.current_ma < $signed({1'b0, r_noload})
                        && r_sdone > smsg_pkg::NOLOAD_AFTER_STEPS) begin
                        n_loss = 1'b1;
                    end
                    if (w_item.current_ma > $signed({1'b0, r_overload})) begin
                        n_loss = 1'b1;
                    end
                end
            end
            smsg_pkg::OP_MOVE, smsg_pkg::OP_PRIME, smsg_pkg::OP_REWIND,
            smsg_pkg::OP_BOLUS, smsg_pkg::OP_HOME: begin
                if (v_busy) begin
                    v_ev = smsg_pkg::EV_REJECT;
                end else if (w_item.opcode == smsg_pkg::OP_HOME) begin
                    n_pos = '0;
                end else if (w_item.opcode == smsg_pkg::OP_BOLUS) begin
                    if (w_item.step_amount != 32'd0) begin
                        n_inb = 1'b1;
                        n_abort = 1'b0;
                        n_btot = w_item.step_amount;
                        n_bdone = '0;
                        n_en = 1'b0;
                        v_seg = 1'b1;
                    end
                end else begin
                    if (w_item.opcode == smsg_pkg::OP_MOVE) begin
                        v_mdir = w_item.direction;
                        v_msteps = w_item.step_amount;
                    end else if (w_item.opcode == smsg_pkg::OP_PRIME) begin
                        v_mdir = 1'b1;
                        v_msteps = (w_item.step_amount != 32'd0) ? w_item.step_amount
                                   : {16'd0, PRIME_DEFAULT_STEPS};
                    end else begin
                        v_mdir = 1'b0;
                        v_msteps = (w_item.step_amount != 32'd0) ? w_item.step_amount
                                   : r_pos;
                    end
                    if (v_msteps == 32'd0) begin
                        v_ev = smsg_pkg::EV_MOVE_OK;
                    end else begin
                        v_move = 1'b1;
                    end
                end
            end
            smsg_pkg::OP_STOP: begin
                if (r_inb) begin
                    v_ev = smsg_pkg::EV_BOLUS_ABORT;
                    n_inb = 1'b0; n_pausing = 1'b0; n_abort = 1'b0;
                    n_moving = 1'b0; n_phase = 1'b0; n_en = 1'b1;
                end else begin
                    if (r_moving) begin
                        v_ev = r_loss ? smsg_pkg::EV_MOVE_LOSS : smsg_pkg::EV_MOVE_OK;
                    end
                    n_moving = 1'b0;
                    n_phase = 1'b0;
                    n_en = 1'b1;
                end
            end
            smsg_pkg::OP_CANCEL: begin
                if (r_inb) begin
                    n_abort = 1'b1;
                end
            end
            default: begin
                v_ev = smsg_pkg::EV_NONE;
            end
        endcase

        // Segment start with its safety checks.
        if (v_seg) begin
            n_pausing = 1'b0;
            if (n_abort || w_item.inhibit || n_loss) begin
                v_ev = smsg_pkg::EV_BOLUS_ABORT;
                n_inb = 1'b0; n_abort = 1'b0;
                n_moving = 1'b0; n_phase = 1'b0; n_en = 1'b1;
            end else if (n_bdone >= n_btot) begin
                v_ev = smsg_pkg::EV_BOLUS_DONE;
                n_inb = 1'b0; n_abort = 1'b0;
                n_moving = 1'b0; n_phase = 1'b0; n_en = 1'b1;
            end else begin
                v_seg_sz = (r_seg_steps != 16'd0) ? {16'd0, r_seg_steps} : 32'd1;
                v_rem = n_btot - n_bdone;
                v_move = 1'b1;
                v_mdir = 1'b1;
                v_msteps = (v_rem < v_seg_sz) ? v_rem : v_seg_sz;
            end
        end

        if (v_move) begin
            n_hp = w_hp;
            n_dir = v_mdir;
            n_sdone = '0;
            n_star = v_msteps;
            n_phase = 1'b0;
            n_tick = '0;
            n_moving = 1'b1;
            n_loss = 1'b0;
            n_peak = '0;
            n_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_spd <= 16'd1000;   r_bol_spd <= 16'd500;   r_seg_steps <= 16'd100;
            r_seg_pause <= 24'd1000000; r_noload <= 15'd20;  r_overload <= 15'd800;
            r_phase <= 1'b0;  r_sdone <= '0;   r_star <= '0;    r_moving <= 1'b0;
            r_hp <= MIN_HALF_PERIOD; r_tick <= '0; r_dir <= 1'b0; r_pos <= '0;
            r_loss <= 1'b0;   r_peak <= '0;    r_inb <= 1'b0;   r_abort <= 1'b0;
            r_btot <= '0;     r_bdone <= '0;   r_pausing <= 1'b0; r_pcnt <= '0;
            r_en <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smsg_pkg::CFG_DEFAULT_SPEED: r_def_spd   <= i_cfg_data[15:0];
                    smsg_pkg::CFG_BOLUS_SPEED:   r_bol_spd   <= i_cfg_data[15:0];
                    smsg_pkg::CFG_SEG_STEPS:     r_seg_steps <= i_cfg_data[15:0];
                    smsg_pkg::CFG_SEG_PAUSE:     r_seg_pause <= i_cfg_data;
                    smsg_pkg::CFG_NOLOAD:        r_noload    <= i_cfg_data[14:0];
                    smsg_pkg::CFG_OVERLOAD:      r_overload  <= i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_phase <= n_phase;  r_sdone <= n_sdone;  r_star <= n_star;
                r_moving <= n_moving; r_hp <= n_hp;       r_tick <= n_tick;
                r_dir <= n_dir;      r_pos <= n_pos;      r_loss <= n_loss;
                r_peak <= n_peak;    r_inb <= n_inb;      r_abort <= n_abort;
                r_btot <= n_btot;    r_bdone <= n_bdone;  r_pausing <= n_pausing;
                r_pcnt <= n_pcnt;    r_en <= n_en;
            end
        end
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_out.step_level    <= n_phase;
            r_out.dir_level     <= n_dir;
            r_out.enable_n      <= n_en;
            r_out.busy_res      <= n_moving || n_inb;
            r_out.bolus_running <= n_inb;
            r_out.loss_flag     <= n_loss;
            r_out.position      <= n_pos;
            r_out.peak_ma       <= n_peak;
            r_out.delivered     <= n_bdone;
            r_out.event_res     <= v_ev;
        end
    end

    assign o_out = r_out;
endmodule
`default_nettype wire

// ===== rtl/stepper_move_sequencer_stall_guard_unit.sv =====
// ============================================================================
// stepper_move_sequencer_stall_guard_unit
// Step/dir pulse generator with move sequencing, stall guard and bolus.
// ============================================================================
// Every input beat gives exactly one result beat. Ticks, current samples,
// stop, cancel, set home and ignored opcodes execute in the cycle they are
// accepted, so a stream of ticks runs at one beat per clock as long as the
// result side keeps up. Move, prime, rewind and bolus commands, and every
// tick that arrives during the pause between bolus segments, first compute
// the half period with a bit-serial divider; the controller then takes no
// beat until it is idle again, after its divide state and the execute state
// that registers the result. The divider is the only multi-cycle unit.
// The result register is released when the downstream side takes it, and the
// next beat may be accepted in that same cycle. Configuration writes take
// effect at once and are meant to be made while no command is in flight.
`default_nettype none
module stepper_move_sequencer_stall_guard_unit #(
    parameter logic [18:0] HALF_PERIOD_DIVIDEND = 19'd500000,
    parameter logic [18:0] MIN_HALF_PERIOD      = 19'd20,
    parameter logic [15:0] PRIME_DEFAULT_STEPS  = 16'd2000
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire smsg_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output smsg_pkg::t_out_item              o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [smsg_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire logic [smsg_pkg::CDAT_W-1:0] i_cfg_data
);
    smsg_pkg::t_cmd    w_cmd;
    smsg_pkg::t_status w_status;

    // The controller decides when a beat executes and when the divider runs.
    smsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds all motion state and the result register.
    smsg_dp #(
        .HALF_PERIOD_DIVIDEND (HALF_PERIOD_DIVIDEND),
        .MIN_HALF_PERIOD      (MIN_HALF_PERIOD),
        .PRIME_DEFAULT_STEPS  (PRIME_DEFAULT_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out      (o_out_data)
    );

`ifndef SYNTHESIS
    // A beat must never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten while held");

    // A command that needs the divider blocks input while it runs.
    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !o_in_ready)
        else $error("input accepted during division");

    // The divider starts only on an accepted beat.
    a_div_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> (i_in_valid && o_in_ready))
        else $error("divider started without an accepted beat");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the stepper move sequencer with stall guard.
// ============================================================================
// A queue of command and tick beats is filled by the stimulus process and
// drained by a clocked driver with random gaps. Each accepted beat runs
// through a cycle-free model of the sequencer, and the expected result is
// queued. A clocked monitor with random back-pressure compares every result
// field by field with the oldest expectation. The run is split into phases,
// each with its own register setting; registers change only while idle.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int LIMIT_CYCLES = 3000000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          o_in_ready;
    smsg_pkg::t_in_item            in_data = '0;
    logic                          o_out_valid;
    logic                          out_ready = 1'b0;
    smsg_pkg::t_out_item           o_out_data;
    logic                          cfg_we = 1'b0;
    logic [smsg_pkg::CIDX_W-1:0]   cfg_idx = '0;
    logic [smsg_pkg::CDAT_W-1:0]   cfg_data = '0;

    stepper_move_sequencer_stall_guard_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model state, mirrored from reset and register writes.
    // ------------------------------------------------------------------
    logic [31:0] c_dspd, c_bspd, c_seg, c_pause, c_noload, c_over;
    logic        m_phase, m_run, m_dir, m_loss, m_bolus, m_abort, m_pausing, m_en;
    logic [31:0] m_done, m_target, m_hp, m_tick, m_pos, m_peak, m_btotal, m_bdone;
    logic [31:0] m_pcnt;

    smsg_pkg::t_in_item  cmd_fifo[$];
    smsg_pkg::t_out_item expected_q[$];

    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int ev_seen[8];
    int gen_count = 0;
    int gap_max = 10;
    int stall_max = 10;
    int gap_left = 0;
    int stall_left = 0;
    longint cycles = 0;

    function automatic void model_reset();
        c_dspd = 1000; c_bspd = 500; c_seg = 100; c_pause = 1000000;
        c_noload = 20; c_over = 800;
        m_phase = 0; m_done = 0; m_target = 0; m_run = 0; m_hp = 20; m_tick = 0;
        m_dir = 0; m_pos = 0; m_loss = 0; m_peak = 0; m_bolus = 0; m_abort = 0;
        m_btotal = 0; m_bdone = 0; m_pausing = 0; m_pcnt = 0; m_en = 1;
    endfunction

    function automatic void launch_pulses(logic dir, logic [31:0] steps, logic [31:0] spd);
        logic [31:0] hp;
        if (spd == 0) spd = 1;
        hp = 32'd500000 / spd;
        if (hp < 20) hp = 20;
        m_hp = hp & 32'h7FFFF;
        m_dir = dir; m_done = 0; m_target = steps; m_phase = 0; m_tick = 0;
        m_run = 1; m_loss = 0; m_peak = 0; m_en = 0;
    endfunction

    function automatic logic [2:0] close_bolus(logic [2:0] ev);
        m_bolus = 0; m_pausing = 0; m_abort = 0; m_run = 0; m_phase = 0; m_en = 1;
        return ev;
    endfunction

    // Safety checks come first; a segment may be cut short by what is left.
    function automatic logic [2:0] open_segment(logic inh);
        logic [31:0] seg, left;
        m_pausing = 0;
        if (m_abort || inh || m_loss) return close_bolus(smsg_pkg::EV_BOLUS_ABORT);
        if (m_bdone >= m_btotal) return close_bolus(smsg_pkg::EV_BOLUS_DONE);
        seg = (c_seg != 0) ? c_seg : 1;
        left = m_btotal - m_bdone;
        launch_pulses(1'b1, (left < seg) ? left : seg, c_bspd);
        return smsg_pkg::EV_NONE;
    endfunction

    function automatic logic [2:0] advance_tick(logic inh);
        if (m_pausing) begin
            if (m_pcnt < 32'hFFFFFF) m_pcnt++;
            if (m_pcnt >= c_pause) return open_segment(inh);
            return smsg_pkg::EV_NONE;
        end
        if (!m_run) return smsg_pkg::EV_NONE;
        m_tick = (m_tick + 1) & 32'h7FFFF;
        if (m_tick < m_hp) return smsg_pkg::EV_NONE;
        m_tick = 0;
        if (!m_phase) begin
            m_phase = 1;
            return smsg_pkg::EV_NONE;
        end
        // Falling edge of STEP: one full step is out.
        m_phase = 0;
        m_done++;
        m_pos = m_dir ? m_pos + 1 : m_pos - 1;
        if (m_bolus) m_bdone++;
        if (m_done < m_target) return smsg_pkg::EV_NONE;
        m_run = 0;
        if (!m_bolus) begin
            m_en = 1;
            return m_loss ? smsg_pkg::EV_MOVE_LOSS : smsg_pkg::EV_MOVE_OK;
        end
        if (m_loss || m_abort) return close_bolus(smsg_pkg::EV_BOLUS_ABORT);
        if (m_bdone >= m_btotal) return close_bolus(smsg_pkg::EV_BOLUS_DONE);
        m_pausing = 1;
        m_pcnt = 0;
        return smsg_pkg::EV_NONE;
    endfunction

    function automatic logic [2:0] request_move(logic dir, logic [31:0] steps,
                                                logic [15:0] spd);
        if (steps == 0) return smsg_pkg::EV_MOVE_OK;
        launch_pulses(dir, steps, (spd != 0) ? {16'd0, spd} : c_dspd);
        return smsg_pkg::EV_NONE;
    endfunction

    function automatic smsg_pkg::t_out_item sequencer_step(smsg_pkg::t_in_item it);
        smsg_pkg::t_out_item r;
        logic [2:0] ev;
        int cur;
        logic busy;
        cur = it.current_ma;
        busy = m_run || m_bolus;
        ev = smsg_pkg::EV_NONE;
        case (it.opcode)
            smsg_pkg::OP_TICK: ev = advance_tick(it.inhibit);
            smsg_pkg::OP_SAMPLE: begin
                if (m_run) begin
                    if (cur > int'(m_peak)) m_peak = cur & 32'h7FFF;
                    if (cur < int'(c_noload) && m_done > smsg_pkg::NOLOAD_AFTER_STEPS)
                        m_loss = 1;
                    if (cur > int'(c_over)) m_loss = 1;
                end
            end
            smsg_pkg::OP_MOVE, smsg_pkg::OP_PRIME, smsg_pkg::OP_REWIND,
            smsg_pkg::OP_BOLUS, smsg_pkg::OP_HOME: begin
                if (busy) ev = smsg_pkg::EV_REJECT;
                else if (it.opcode == smsg_pkg::OP_MOVE)
                    ev = request_move(it.direction, it.step_amount, it.step_rate);
                else if (it.opcode == smsg_pkg::OP_PRIME)
                    ev = request_move(1'b1, (it.step_amount != 0) ? it.step_amount : 2000,
                                      it.step_rate);
                else if (it.opcode == smsg_pkg::OP_REWIND)
                    ev = request_move(1'b0, (it.step_amount != 0) ? it.step_amount : m_pos,
                                      it.step_rate);
                else if (it.opcode == smsg_pkg::OP_HOME) m_pos = 0;
                else if (it.step_amount != 0) begin
                    m_bolus = 1; m_abort = 0; m_btotal = it.step_amount; m_bdone = 0;
                    m_en = 0;
                    ev = open_segment(it.inhibit);
                end
            end
            smsg_pkg::OP_STOP: begin
                if (m_bolus) ev = close_bolus(smsg_pkg::EV_BOLUS_ABORT);
                else begin
                    if (m_run) ev = m_loss ? smsg_pkg::EV_MOVE_LOSS : smsg_pkg::EV_MOVE_OK;
                    m_run = 0; m_phase = 0; m_en = 1;
                end
            end
            smsg_pkg::OP_CANCEL: if (m_bolus) m_abort = 1;
            default: ;
        endcase
        r.step_level = m_phase;
        r.dir_level = m_dir;
        r.enable_n = m_en;
        r.busy_res = m_run || m_bolus;
        r.bolus_running = m_bolus;
        r.loss_flag = m_loss;
        r.position = m_pos;
        r.peak_ma = m_peak[14:0];
        r.delivered = m_bdone;
        r.event_res = ev;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat at a time from cmd_fifo, random gap before each.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic nv;
        int g;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nv = in_valid;
            g = gap_left;
            if (in_valid && o_in_ready) begin
                expected_q.push_back(sequencer_step(in_data));
                beats_in++;
                nv = 1'b0;
            end
            if (!nv && cmd_fifo.size() > 0) begin
                if (g > 0) g--;
                else begin
                    in_data <= cmd_fifo.pop_front();
                    nv = 1'b1;
                    g = $urandom_range(0, gap_max);
                end
            end
            gap_left = g;
            in_valid <= nv;
        end
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("result beat %0d: %s is 0x%0h, model says 0x%0h", beats_out, field, got,
                 want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and field-by-field comparison.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        smsg_pkg::t_out_item want;
        logic rv;
        int s;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            s = stall_left;
            if (o_out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("result beat %0d arrived with nothing expected", beats_out);
                end else begin
                    want = expected_q.pop_front();
                    ev_seen[o_out_data.event_res]++;
                    if (o_out_data.step_level !== want.step_level)
                        report_mismatch("step_level", 32'(o_out_data.step_level),
                                        32'(want.step_level));
                    if (o_out_data.dir_level !== want.dir_level)
                        report_mismatch("dir_level", 32'(o_out_data.dir_level),
                                        32'(want.dir_level));
                    if (o_out_data.enable_n !== want.enable_n)
                        report_mismatch("enable_n", 32'(o_out_data.enable_n),
                                        32'(want.enable_n));
                    if (o_out_data.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 32'(o_out_data.busy_res),
                                        32'(want.busy_res));
                    if (o_out_data.bolus_running !== want.bolus_running)
                        report_mismatch("bolus_running", 32'(o_out_data.bolus_running),
                                        32'(want.bolus_running));
                    if (o_out_data.loss_flag !== want.loss_flag)
                        report_mismatch("loss_flag", 32'(o_out_data.loss_flag),
                                        32'(want.loss_flag));
                    if (o_out_data.position !== want.position)
                        report_mismatch("position", o_out_data.position, want.position);
                    if (o_out_data.peak_ma !== want.peak_ma)
                        report_mismatch("peak_ma", 32'(o_out_data.peak_ma),
                                        32'(want.peak_ma));
                    if (o_out_data.delivered !== want.delivered)
                        report_mismatch("delivered", o_out_data.delivered, want.delivered);
                    if (o_out_data.event_res !== want.event_res)
                        report_mismatch("event_res", 32'(o_out_data.event_res),
                                        32'(want.event_res));
                end
                beats_out++;
                s = $urandom_range(0, stall_max);
            end
            if (s > 0) begin
                rv = 1'b0;
                s--;
            end else begin
                rv = 1'b1;
            end
            stall_left = s;
            out_ready <= rv;
        end
    end

    // A hung handshake must not hang the run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Every field is random unless the caller overrides it, so unused fields
    // still see both values on every bit.
    function automatic smsg_pkg::t_in_item random_beat(logic [3:0] op);
        smsg_pkg::t_in_item it;
        it.opcode = op;
        it.direction = 1'($urandom_range(0, 1));
        it.step_amount = $urandom;
        it.step_rate = 16'($urandom);
        it.current_ma = 16'($urandom);
        it.inhibit = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send(logic [3:0] op, logic [31:0] amt, logic [15:0] spd,
                        logic dir = 1'b1, logic inh = 1'b0);
        smsg_pkg::t_in_item it;
        it = random_beat(op);
        it.step_amount = amt;
        it.step_rate = spd;
        it.direction = dir;
        it.inhibit = inh;
        cmd_fifo.push_back(it);
        gen_count++;
    endtask

    task automatic send_sample(logic signed [15:0] cur);
        smsg_pkg::t_in_item it;
        it = random_beat(smsg_pkg::OP_SAMPLE);
        it.current_ma = cur;
        cmd_fifo.push_back(it);
        gen_count++;
    endtask

    // Ticks with the odd current sample, cancel or stray command mixed in.
    task automatic send_ticks(int n, logic with_cancel);
        smsg_pkg::t_in_item it;
        int k;
        for (k = 0; k < n; k++) begin
            it = random_beat(smsg_pkg::OP_TICK);
            it.inhibit = ($urandom_range(0, 19) == 0);
            cmd_fifo.push_back(it);
            gen_count++;
            case ($urandom_range(0, 39))
                0, 1: send_sample($urandom_range(0, 1) ? 16'($urandom_range(0, 1200))
                                                       : 16'($urandom));
                2: if (with_cancel) send(smsg_pkg::OP_CANCEL, $urandom, 16'($urandom));
                3: begin
                    cmd_fifo.push_back(random_beat(
                        4'($urandom_range(smsg_pkg::OP_MOVE, smsg_pkg::OP_HOME))));
                    gen_count++;
                end
                default: ;
            endcase
        end
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(25000, 65535));
        endcase
    endfunction

    task automatic wait_idle();
        wait (cmd_fifo.size() == 0 && !in_valid && expected_q.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [smsg_pkg::CIDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[smsg_pkg::CDAT_W-1:0];
        case (idx)
            smsg_pkg::CFG_DEFAULT_SPEED: c_dspd = val & 32'hFFFF;
            smsg_pkg::CFG_BOLUS_SPEED:   c_bspd = val & 32'hFFFF;
            smsg_pkg::CFG_SEG_STEPS:     c_seg = val & 32'hFFFF;
            smsg_pkg::CFG_SEG_PAUSE:     c_pause = val & 32'hFFFFFF;
            smsg_pkg::CFG_NOLOAD:        c_noload = val & 32'h7FFF;
            smsg_pkg::CFG_OVERLOAD:      c_over = val & 32'h7FFF;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] dspd, logic [31:0] bspd, logic [31:0] seg,
                            logic [31:0] pause, logic [31:0] noload, logic [31:0] over);
        wait_idle();
        write_reg(smsg_pkg::CFG_DEFAULT_SPEED, dspd);
        write_reg(smsg_pkg::CFG_BOLUS_SPEED, bspd);
        write_reg(smsg_pkg::CFG_SEG_STEPS, seg);
        write_reg(smsg_pkg::CFG_SEG_PAUSE, pause);
        write_reg(smsg_pkg::CFG_NOLOAD, noload);
        write_reg(smsg_pkg::CFG_OVERLOAD, over);
    endtask

    // Random phase: mostly complete move and bolus sequences, each closed by
    // a stop so the next sequence starts from idle, plus some raw noise.
    task automatic random_phase(int budget);
        int stop_at, amt;
        logic [3:0] op;
        stop_at = gen_count + budget;
        while (gen_count < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
                gap_max = 0;
                stall_max = 0;
            end else begin
                gap_max = 10;
                stall_max = 10;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    op = 4'(smsg_pkg::OP_MOVE + $urandom_range(0, 2));
                    amt = $urandom_range(0, 3);
                    if (op != smsg_pkg::OP_REWIND && amt == 0 && $urandom_range(0, 1))
                        amt = 1;
                    send(op, amt, pick_speed(), 1'($urandom_range(0, 1)));
                    send_ticks(((amt == 0) ? 3 : amt) * 42 + $urandom_range(0, 10), 1'b0);
                    send(smsg_pkg::OP_STOP, $urandom, 16'($urandom));
                end
                4, 5, 6: begin
                    amt = $urandom_range(1, 6);
                    send(smsg_pkg::OP_BOLUS, amt, 16'($urandom), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 9) == 0);
                    send_ticks(amt * 45 + 20, 1'b1);
                    send(smsg_pkg::OP_STOP, $urandom, 16'($urandom));
                end
                7: begin
                    repeat (3) begin
                        cmd_fifo.push_back(random_beat(4'($urandom_range(0, 15))));
                        gen_count++;
                    end
                    send(smsg_pkg::OP_STOP, $urandom, 16'($urandom));
                end
                8: send(smsg_pkg::OP_HOME, $urandom, 16'($urandom));
                default: send_ticks($urandom_range(1, 8), 1'b1);
            endcase
        end
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: idle behavior and edge cases.
        send(smsg_pkg::OP_TICK, 0, 0);
        send_sample(16'sd1000);
        send(smsg_pkg::OP_STOP, 0, 0);
        send(smsg_pkg::OP_CANCEL, 0, 0);
        send(4'd9, 32'hFFFF_FFFF, 16'hFFFF);
        send(4'd15, 0, 0);
        send(smsg_pkg::OP_MOVE, 0, 0);
        send(smsg_pkg::OP_REWIND, 0, 0);
        send(smsg_pkg::OP_BOLUS, 0, 0);
        send(smsg_pkg::OP_HOME, 0, 0);
        send(smsg_pkg::OP_MOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send(smsg_pkg::OP_MOVE, 1, 1);
        send(smsg_pkg::OP_PRIME, 0, 0);
        send(smsg_pkg::OP_REWIND, 0, 0);
        send(smsg_pkg::OP_BOLUS, 5, 0);
        send(smsg_pkg::OP_HOME, 0, 0);
        send_sample(16'sh7FFF);
        send_sample(-16'sd32768);
        send(smsg_pkg::OP_STOP, 0, 0);
        send(smsg_pkg::OP_PRIME, 0, 0);
        send(smsg_pkg::OP_STOP, 0, 0);
        send(smsg_pkg::OP_BOLUS, 3, 0, 1'b1, 1'b1);
        send(smsg_pkg::OP_BOLUS, 32'hFFFF_FFFF, 0);
        send(smsg_pkg::OP_CANCEL, 0, 0);
        send(smsg_pkg::OP_STOP, 0, 0);

        // Fast motion, single-step segments with no pause, stall guard on
        // no-load only, for negative samples.
        set_regs(65535, 65535, 1, 0, 0, 32767);
        random_phase(350);

        // Moderate speeds, short pauses, both guards armed.
        set_regs(25000, 30000, 2, 3, 200, 800);
        random_phase(350);

        // Zero rate and segment registers, the longest pause, and
        // guards at their extremes.
        set_regs(0, 0, 0, 24'hFFFFFF, 32767, 0);
        random_phase(150);

        set_regs(1, 50000, 65535, 1, 20, 1000);
        random_phase(350);

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d beats, checked %0d results over the reset and four other settings.",
                 beats_in, beats_out);
        $display("Events: ok %0d, loss %0d, bolus done %0d, aborted %0d, rejected %0d.",
                 ev_seen[smsg_pkg::EV_MOVE_OK], ev_seen[smsg_pkg::EV_MOVE_LOSS],
                 ev_seen[smsg_pkg::EV_BOLUS_DONE], ev_seen[smsg_pkg::EV_BOLUS_ABORT],
                 ev_seen[smsg_pkg::EV_REJECT]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== stepper_move_sequencer_stall_guard_unit.f =====
rtl/smsg_pkg.sv
rtl/smsg_div.sv
rtl/smsg_ctrl.sv
rtl/smsg_dp.sv
rtl/stepper_move_sequencer_stall_guard_unit.sv
tb/tb_top.sv
